### rtl/core/mva_pkg.sv
package mva_pkg;

   // Field widths
   localparam int COORD_BITS = 16;
   localparam int CNT_W      = 16;
   localparam int VOL_W      = 64;
   localparam int VCNT_W     = 3;
   localparam int CSR_IDX_W  = 2;

   // Counter limits
   localparam logic [CNT_W-1:0]  MAX_FACES = 16'd65535;
   localparam logic [CNT_W-1:0]  BAD_MAX   = 16'd65535;
   localparam logic [VCNT_W-1:0] VCNT_MAX  = 3'd7;

   // Datapath widths, all follow from the coordinate width
   localparam int CS_W    = 2 * COORD_BITS + 4;   // cross product sum
   localparam int PS_W    = COORD_BITS + 3;       // position sum
   localparam int LO_W    = COORD_BITS + 2;       // low chunk of a cross sum
   localparam int DIF_W   = COORD_BITS + 4;       // position sum minus n * ref
   localparam int MUL_A_W = COORD_BITS + 3;
   localparam int MUL_B_W = COORD_BITS + 4;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int PART_W  = 3 * COORD_BITS + 10;  // full cross sum times difference
   localparam int PART_XW = (PART_W > VOL_W) ? PART_W : VOL_W;

   localparam logic signed [VOL_W-1:0] VOL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [VOL_W-1:0] VOL_MIN = 64'sh8000_0000_0000_0000;

   // Sequencer step limits
   localparam logic [2:0] CROSS_LAST = 3'd6;
   localparam logic [1:0] COMP_LAST  = 2'd2;
   localparam logic [1:0] PHASE_LAST = 2'd3;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_X = 2'd0,
      CSR_REF_Y = 2'd1,
      CSR_REF_Z = 2'd2
   } mva_csr_type;

   // Sequencer states
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CROSS = 7'b0000010,
      ST_CLOSE = 7'b0000100,
      ST_DOT   = 7'b0001000,
      ST_SCALE = 7'b0010000,
      ST_ACCUM = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } mva_state_type;

   typedef struct packed {
      mva_state_type state;
      logic [2:0]    stp;   // cross product step
      logic [1:0]    cmp;   // dot product component
      logic [1:0]    phs;   // dot product phase
      logic          clo;   // cross step closes the face
   } mva_ctrl_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
      logic signed [COORD_BITS-1:0] coord_z;
      logic                         face_end;
      logic                         mesh_end;
   } mva_req_type;

   typedef struct packed {
      logic signed [VOL_W-1:0] volume_x72;
      logic [CNT_W-1:0]        face_count;
      logic [CNT_W-1:0]        bad_face_count;
      logic                    saturated;
   } mva_rsp_type;

endpackage

### rtl/core/mesh_volume_accumulator_unit.sv
// Channel  Ports                           Direction  Transfer when
// req      req_valid req_stall req_data    in         req_valid && !req_stall
// rsp      rsp_valid rsp_stall rsp_data    out        rsp_valid && !rsp_stall
// csr      csr_we csr_index csr_wdata      in         csr_we
//
// A vertex that opens a face or follows the fourth vertex is taken without a cross step; any other
// vertex runs the cross steps: the one shared multiplier forms six cross products, one per cycle,
// plus a drain. Closing a 3- or 4-vertex face adds the closing cross product, a dot product in
// split partial products, weight and accumulate; a bad face only closes; mesh end adds emit.
// Reset is synchronous and clears reference point, counters and volume; no clearing pass.
// The result waits in an output register; only a second mesh end stalls on a full one.
module mesh_volume_accumulator_unit
   import mva_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mva_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mva_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata
);

   localparam int CB = COORD_BITS;

   mva_ctrl_type ctrl;
   logic         req_xfer;
   logic         rsp_free;
   logic         in_idle;

   logic signed [CB-1:0]     ref_ff [3], ref_in [3];
   logic signed [CB-1:0]     first_ff [3], first_in [3];
   logic signed [CB-1:0]     prev_ff [3], prev_in [3];
   logic signed [CB-1:0]     vin_ff [3], vin_in [3];
   logic signed [CS_W-1:0]   cs_ff [3], cs_in [3];
   logic signed [PS_W-1:0]   pos_ff [3], pos_in [3];
   logic [VCNT_W-1:0]        vcnt_ff, vcnt_in;
   logic signed [PART_W-1:0] part_ff, part_in;
   logic signed [VOL_W-1:0]  dot_ff, dot_in;
   logic signed [VOL_W-1:0]  vol_ff, vol_in;
   logic [CNT_W-1:0]         fseen_ff, fseen_in;
   logic [CNT_W-1:0]         fbad_ff, fbad_in;
   logic                     sat_ff, sat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mva_rsp_type              rsp_data_ff, rsp_data_in;

   logic signed [CB-1:0]      vreq [3];
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [1:0]                a_idx, b_idx;
   logic signed [CB-1:0]      a_crd, b_crd;
   logic [2:0]                ast;
   logic [1:0]                acc_k;
   logic signed [CS_W-1:0]    cs_sel;
   logic signed [CB-1:0]      ref_sel;
   logic signed [DIF_W-1:0]   nref, diff;
   logic signed [PART_XW-1:0] part_x;
   logic [PART_XW-64:0]       part_hi;
   logic                      part_ovf;
   logic signed [VOL_W-1:0]   part_c;
   logic signed [VOL_W-1:0]   sa_a, sa_b, sa_res;
   logic signed [VOL_W:0]     sa_sum;
   logic                      sa_ovf;
   logic signed [VOL_W+2:0]   sc_x, sc_sum;
   logic [3:0]                sc_hi;
   logic                      sc_ovf;
   logic signed [VOL_W-1:0]   sc_res;
   logic                      emit_load;

   assign in_idle   = (ctrl.state == ST_IDLE);
   assign req_stall = !in_idle;
   assign req_xfer  = req_valid && in_idle;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign vreq[0] = req_data.coord_x;
   assign vreq[1] = req_data.coord_y;
   assign vreq[2] = req_data.coord_z;

   mva_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_xfer (req_xfer),
      .req_data (req_data),
      .vcnt     (vcnt_ff),
      .rsp_free (rsp_free),
      .ctrl     (ctrl)
   );

   // Cross product operand order: x = a1*b2 - a2*b1, y = a2*b0 - a0*b2, z = a0*b1 - a1*b0
   always_comb begin
      case (ctrl.stp)
         3'd0:    begin a_idx = 2'd1; b_idx = 2'd2; end
         3'd1:    begin a_idx = 2'd2; b_idx = 2'd1; end
         3'd2:    begin a_idx = 2'd2; b_idx = 2'd0; end
         3'd3:    begin a_idx = 2'd0; b_idx = 2'd2; end
         3'd4:    begin a_idx = 2'd0; b_idx = 2'd1; end
         default: begin a_idx = 2'd1; b_idx = 2'd0; end
      endcase
   end

   assign a_crd = prev_ff[a_idx];
   assign b_crd = ctrl.clo ? first_ff[b_idx] : vin_ff[b_idx];

   // Difference of position sum and n times the reference point
   assign cs_sel  = cs_ff[ctrl.cmp];
   assign ref_sel = ref_ff[ctrl.cmp];
   assign nref = (vcnt_ff == 3'd4) ? {{2{ref_sel[CB-1]}}, ref_sel, 2'b00}
                                   : ({{4{ref_sel[CB-1]}}, ref_sel}
                                      + {{3{ref_sel[CB-1]}}, ref_sel, 1'b0});
   assign diff = {pos_ff[ctrl.cmp][PS_W-1], pos_ff[ctrl.cmp]} - nref;

   // Multiplier operands: coordinates, or a cross sum chunk times the difference
   always_comb begin
      if (ctrl.state == ST_CROSS) begin
         mul_a = {{3{a_crd[CB-1]}}, a_crd};
         mul_b = {{4{b_crd[CB-1]}}, b_crd};
      end else begin
         if (ctrl.phs == 2'd0) begin
            mul_a = {1'b0, cs_sel[LO_W-1:0]};
         end else begin
            mul_a = {cs_sel[CS_W-1], cs_sel[CS_W-1:LO_W]};
         end
         mul_b = diff;
      end
   end

   mva_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // Product issued in the previous cross step
   assign ast   = ctrl.stp - 3'd1;
   assign acc_k = ast[2:1];

   // Clamp the full partial sum to the volume range
   assign part_x   = PART_XW'(part_ff);
   assign part_hi  = part_x[PART_XW-1:VOL_W-1];
   assign part_ovf = !((&part_hi) || !(|part_hi));
   assign part_c   = part_ovf ? (part_x[PART_XW-1] ? VOL_MIN : VOL_MAX)
                              : part_x[VOL_W-1:0];

   // Shared saturating adder: dot accumulation, then volume accumulation
   assign sa_a   = (ctrl.state == ST_ACCUM) ? vol_ff : dot_ff;
   assign sa_b   = (ctrl.state == ST_ACCUM) ? dot_ff : part_c;
   assign sa_sum = (VOL_W+1)'(sa_a) + (VOL_W+1)'(sa_b);
   assign sa_ovf = sa_sum[VOL_W] ^ sa_sum[VOL_W-1];
   assign sa_res = sa_ovf ? (sa_sum[VOL_W] ? VOL_MIN : VOL_MAX) : sa_sum[VOL_W-1:0];

   // Face weight: 4 for triangles, 3 for quads
   assign sc_x   = (VOL_W+3)'(dot_ff);
   assign sc_sum = (vcnt_ff == 3'd3) ? (sc_x <<< 2) : ((sc_x <<< 1) + sc_x);
   assign sc_hi  = sc_sum[VOL_W+2:VOL_W-1];
   assign sc_ovf = !((&sc_hi) || !(|sc_hi));
   assign sc_res = sc_ovf ? (sc_sum[VOL_W+2] ? VOL_MIN : VOL_MAX) : sc_sum[VOL_W-1:0];

   assign emit_load = (ctrl.state == ST_EMIT) && rsp_free;

   // Datapath next values
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ref_in[i]   = ref_ff[i];
         first_in[i] = first_ff[i];
         prev_in[i]  = prev_ff[i];
         vin_in[i]   = vin_ff[i];
         cs_in[i]    = cs_ff[i];
         pos_in[i]   = pos_ff[i];
      end
      vcnt_in     = vcnt_ff;
      part_in     = part_ff;
      dot_in      = dot_ff;
      vol_in      = vol_ff;
      fseen_in    = fseen_ff;
      fbad_in     = fbad_ff;
      sat_in      = sat_ff;
      rsp_data_in = rsp_data_ff;

      // Reference point writes
      if (csr_we) begin
         case (csr_index)
            CSR_REF_X: ref_in[0] = csr_wdata;
            CSR_REF_Y: ref_in[1] = csr_wdata;
            CSR_REF_Z: ref_in[2] = csr_wdata;
            default:   ;
         endcase
      end

      case (ctrl.state)
         ST_IDLE: begin
            if (req_xfer) begin
               vcnt_in = (vcnt_ff == VCNT_MAX) ? vcnt_ff : vcnt_ff + 3'd1;
               for (int i = 0; i < 3; i++) begin
                  vin_in[i] = vreq[i];
                  if (vcnt_ff == 3'd0) begin
                     first_in[i] = vreq[i];
                     prev_in[i]  = vreq[i];
                     pos_in[i]   = PS_W'(vreq[i]);
                     cs_in[i]    = '0;
                  end else if (vcnt_ff < 3'd4) begin
                     pos_in[i] = pos_ff[i] + PS_W'(vreq[i]);
                  end else begin
                     prev_in[i] = vreq[i];
                  end
               end
            end
         end
         ST_CROSS: begin
            if (ctrl.stp != 3'd0) begin
               if (ast[0]) begin
                  cs_in[acc_k] = cs_ff[acc_k] - prod[CS_W-1:0];
               end else begin
                  cs_in[acc_k] = cs_ff[acc_k] + prod[CS_W-1:0];
               end
            end
            if ((ctrl.stp == CROSS_LAST) && !ctrl.clo) begin
               for (int i = 0; i < 3; i++) begin
                  prev_in[i] = vin_ff[i];
               end
            end
         end
         ST_CLOSE: begin
            if (vcnt_ff inside {3'd3, 3'd4}) begin
               dot_in = '0;
            end else begin
               vcnt_in = '0;
               if (fbad_ff < BAD_MAX) begin
                  fbad_in = fbad_ff + 16'd1;
               end
            end
         end
         ST_DOT: begin
            case (ctrl.phs)
               2'd1: part_in = PART_W'(prod);
               2'd2: part_in = part_ff + {prod[PROD_W-1], prod, {LO_W{1'b0}}};
               2'd3: begin
                  dot_in = sa_res;
                  sat_in = sat_ff | part_ovf | sa_ovf;
               end
               default: ;
            endcase
         end
         ST_SCALE: begin
            dot_in = sc_res;
            sat_in = sat_ff | sc_ovf;
         end
         ST_ACCUM: begin
            vol_in  = sa_res;
            sat_in  = sat_ff | sa_ovf;
            vcnt_in = '0;
            if (fseen_ff < MAX_FACES) begin
               fseen_in = fseen_ff + 16'd1;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               rsp_data_in = '{volume_x72: vol_ff, face_count: fseen_ff,
                               bad_face_count: fbad_ff, saturated: sat_ff};
               vol_in   = '0;
               fseen_in = '0;
               fbad_in  = '0;
               sat_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Output register: held until transfer
   assign rsp_valid_in = emit_load || (rsp_valid_ff && rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ref_ff[i] <= '0;
         end
         vcnt_ff      <= '0;
         vol_ff       <= '0;
         fseen_ff     <= '0;
         fbad_ff      <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < 3; i++) begin
            ref_ff[i] <= ref_in[i];
         end
         vcnt_ff      <= vcnt_in;
         vol_ff       <= vol_in;
         fseen_ff     <= fseen_in;
         fbad_ff      <= fbad_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         first_ff[i] <= first_in[i];
         prev_ff[i]  <= prev_in[i];
         vin_ff[i]   <= vin_in[i];
         cs_ff[i]    <= cs_in[i];
         pos_ff[i]   <= pos_in[i];
      end
      part_ff     <= part_in;
      dot_ff      <= dot_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### rtl/core/mva_mul.sv
module mva_mul
   import mva_pkg::*;
#(
   parameter int A_W = MUL_A_W,
   parameter int B_W = MUL_B_W
) (
   input  logic                       clock,
   input  logic signed [A_W-1:0]      op_a,
   input  logic signed [B_W-1:0]      op_b,
   output logic signed [A_W+B_W-1:0]  prod_ff
);

   logic signed [A_W+B_W-1:0] prod_in;

   // Shared signed multiplier, registered output
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### rtl/core/mva_ctrl.sv
module mva_ctrl
   import mva_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_xfer,
   input  mva_req_type       req_data,
   input  logic [VCNT_W-1:0] vcnt,
   input  logic              rsp_free,
   output mva_ctrl_type      ctrl
);

   mva_state_type st_ff, st_in;
   logic [2:0]    stp_ff, stp_in;
   logic [1:0]    cmp_ff, cmp_in;
   logic [1:0]    phs_ff, phs_in;
   logic          clo_ff, clo_in;
   logic          fend_ff, fend_in;
   logic          mend_ff, mend_in;

   // Next state
   always_comb begin
      st_in   = st_ff;
      stp_in  = stp_ff;
      cmp_in  = cmp_ff;
      phs_in  = phs_ff;
      clo_in  = clo_ff;
      fend_in = fend_ff;
      mend_in = mend_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               fend_in = req_data.face_end | req_data.mesh_end;
               mend_in = req_data.mesh_end;
               clo_in  = 1'b0;
               stp_in  = '0;
               if (vcnt inside {[3'd1:3'd3]}) begin
                  st_in = ST_CROSS;
               end else if (req_data.face_end | req_data.mesh_end) begin
                  st_in = ST_CLOSE;
               end
            end
         end
         ST_CROSS: begin
            if (stp_ff == CROSS_LAST) begin
               stp_in = '0;
               if (clo_ff) begin
                  st_in  = ST_DOT;
                  cmp_in = '0;
                  phs_in = '0;
               end else if (fend_ff) begin
                  st_in = ST_CLOSE;
               end else begin
                  st_in = ST_IDLE;
               end
            end else begin
               stp_in = stp_ff + 3'd1;
            end
         end
         ST_CLOSE: begin
            if (vcnt inside {3'd3, 3'd4}) begin
               st_in  = ST_CROSS;
               clo_in = 1'b1;
               stp_in = '0;
            end else begin
               st_in = mend_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_DOT: begin
            phs_in = phs_ff + 2'd1;
            if (phs_ff == PHASE_LAST) begin
               if (cmp_ff == COMP_LAST) begin
                  st_in = ST_SCALE;
               end else begin
                  cmp_in = cmp_ff + 2'd1;
               end
            end
         end
         ST_SCALE: begin
            st_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            st_in = mend_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         stp_ff  <= '0;
         cmp_ff  <= '0;
         phs_ff  <= '0;
         clo_ff  <= 1'b0;
         fend_ff <= 1'b0;
         mend_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         stp_ff  <= stp_in;
         cmp_ff  <= cmp_in;
         phs_ff  <= phs_in;
         clo_ff  <= clo_in;
         fend_ff <= fend_in;
         mend_ff <= mend_in;
      end
   end

   assign ctrl = '{state: st_ff, stp: stp_ff, cmp: cmp_ff, phs: phs_ff, clo: clo_ff};

endmodule
